@@ hw/rtl/afs_pkg.sv @@
`default_nettype none

package afs_pkg;

	// Field widths
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned PERIOD_W = 10;
	localparam int unsigned FIRST_W  = 10;
	localparam int unsigned FRAME_W  = 11;
	localparam int unsigned TIME_W   = 31;
	localparam int unsigned STAMP_W  = 32;
	localparam int unsigned BLEND_W  = 17;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned CIDX_W   = 3;
	localparam int unsigned CDATA_W  = 11;
	localparam int unsigned DSTEP_W  = 6;

	// Event kinds
	localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESET   = 2'd2;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_FRAME_COUNT  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_FRAME_PERIOD = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_LOOP_ENABLE  = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_REV_ENABLE   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_FIRST_FRAME  = 3'd4;

	// Configuration reset values
	localparam logic [COUNT_W-1:0]  RST_FRAME_COUNT  = 11'd1;
	localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD = 10'd100;
	localparam logic                RST_LOOP_ENABLE  = 1'b1;
	localparam logic                RST_REV_ENABLE   = 1'b0;
	localparam logic [FIRST_W-1:0]  RST_FIRST_FRAME  = 10'd0;

	// Blend unity in Q1.16
	localparam logic [BLEND_W-1:0] ONE_Q16 = 17'h10000;

	// Divider step counts
	localparam logic [DSTEP_W-1:0] DIV_STEPS_FULL  = 6'd32;
	localparam logic [DSTEP_W-1:0] DIV_STEPS_BLEND = 6'd17;

	// Effective configuration, zero count and period already read as one
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [PERIOD_W-1:0] period;
		logic                loop_en;
		logic                rev_en;
		logic [FIRST_W-1:0]  first;
	} cfg_t;

	// Divider launch request
	typedef struct packed {
		logic                go;
		logic [DSTEP_W-1:0]  steps;
		logic [STAMP_W-1:0]  rem_init;
		logic [STAMP_W-1:0]  bits;
		logic [STAMP_W-1:0]  divisor;
	} div_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/afs_cfg.sv @@
`default_nettype none

module afs_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [afs_pkg::CIDX_W-1:0]  index,
	input  wire logic [afs_pkg::CDATA_W-1:0] data,
	output afs_pkg::cfg_t                    cfg
);

	logic [afs_pkg::COUNT_W-1:0]  count_q;
	logic [afs_pkg::PERIOD_W-1:0] period_q;
	logic                         loop_q;
	logic                         rev_q;
	logic [afs_pkg::FIRST_W-1:0]  first_q;

	// Decode register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= afs_pkg::RST_FRAME_COUNT;
			period_q <= afs_pkg::RST_FRAME_PERIOD;
			loop_q   <= afs_pkg::RST_LOOP_ENABLE;
			rev_q    <= afs_pkg::RST_REV_ENABLE;
			first_q  <= afs_pkg::RST_FIRST_FRAME;
		end else if (wr_en) begin
			case (index)
				afs_pkg::CFG_FRAME_COUNT:  count_q  <= data[afs_pkg::COUNT_W-1:0];
				afs_pkg::CFG_FRAME_PERIOD: period_q <= data[afs_pkg::PERIOD_W-1:0];
				afs_pkg::CFG_LOOP_ENABLE:  loop_q   <= data[0];
				afs_pkg::CFG_REV_ENABLE:   rev_q    <= data[0];
				afs_pkg::CFG_FIRST_FRAME:  first_q  <= data[afs_pkg::FIRST_W-1:0];
				default: ;
			endcase
		end
	end

	// Treat a zero count or period as one
	always_comb begin
		cfg.count   = (count_q == '0) ? afs_pkg::COUNT_W'(1) : count_q;
		cfg.period  = (period_q == '0) ? afs_pkg::PERIOD_W'(1) : period_q;
		cfg.loop_en = loop_q;
		cfg.rev_en  = rev_q;
		cfg.first   = first_q;
	end

endmodule

`default_nettype wire

@@ hw/rtl/afs_div.sv @@
`default_nettype none

module afs_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  afs_pkg::div_req_t                req,
	output logic                             done,
	output logic [afs_pkg::STAMP_W-1:0]      quotient,
	output logic [afs_pkg::STAMP_W-1:0]      remainder
);

	logic                         busy_q;
	logic                         done_q;
	logic [afs_pkg::DSTEP_W-1:0]  cnt_q;
	logic [afs_pkg::STAMP_W-1:0]  rem_q;
	logic [afs_pkg::STAMP_W-1:0]  bits_q;
	logic [afs_pkg::STAMP_W-1:0]  quo_q;
	logic [afs_pkg::STAMP_W-1:0]  dvs_q;
	logic [afs_pkg::STAMP_W:0]    trial;
	logic [afs_pkg::STAMP_W:0]    diff;
	logic                         fits;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, bits_q[afs_pkg::STAMP_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Count steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - afs_pkg::DSTEP_W'(1);
				if (cnt_q == afs_pkg::DSTEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then iterate one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q  <= req.rem_init;
			bits_q <= req.bits;
			dvs_q  <= req.divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[afs_pkg::STAMP_W-1:0] : trial[afs_pkg::STAMP_W-1:0];
			bits_q <= {bits_q[afs_pkg::STAMP_W-2:0], 1'b0};
			quo_q  <= {quo_q[afs_pkg::STAMP_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/animation_frame_sequencer.sv @@
`default_nettype none

// Keyframe animation frame timer. Each input word carries an event kind and a
// millisecond time stamp and yields one output word: current frame, previous
// frame and the Q1.16 weight of the previous frame (65536 means one). Items
// are handled one at a time; in_ready is high only while the block is idle.
// Start, reset and unused kinds go straight to the output word. An advance
// that stays within the current frame goes on to the blend weight, which may
// need the division. One that moves to a new frame first runs the frame index
// division (and holds the last frame when looping is off and the index is
// past the end), and a wrap with looping on adds the divide by frame count
// and the start time update. All divisions use the single shared restoring
// divider, which retires one quotient bit per cycle. Configuration is written
// through cfg_wr_en, cfg_index and cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module animation_frame_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [afs_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [afs_pkg::CDATA_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [afs_pkg::KIND_W-1:0]    kind,
	input  wire logic [afs_pkg::TIME_W-1:0]    time_ms,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [afs_pkg::FRAME_W-1:0]        frame_now,
	output logic [afs_pkg::FRAME_W-1:0]        frame_before,
	output logic [afs_pkg::BLEND_W-1:0]        blend_back
);

	localparam int unsigned SW = afs_pkg::STAMP_W;
	localparam int unsigned FW = afs_pkg::FRAME_W;
	localparam int unsigned RW = afs_pkg::TIME_W;
	localparam int unsigned MW = RW + afs_pkg::PERIOD_W;
	localparam int unsigned DW = SW + afs_pkg::BLEND_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_E,
		ST_DIV_N,
		ST_MUL,
		ST_SUM,
		ST_MUL_R,
		ST_AST,
		ST_FRAME,
		ST_BLEND,
		ST_DIV_B,
		ST_OUT
	} state_t;

	afs_pkg::cfg_t     cfg;
	afs_pkg::div_req_t div_req_q;
	logic              div_done;
	logic [SW-1:0]     div_quo;
	logic [SW-1:0]     div_rem;

	state_t            state_q;
	logic [RW-1:0]     now_q;
	logic [SW-1:0]     ast_q;
	logic [SW-1:0]     nft_q;
	logic [SW-1:0]     pft_q;
	logic [FW-1:0]     cur_q;
	logic [FW-1:0]     prv_q;
	logic [RW-1:0]     rel_q;
	logic [RW-1:0]     mul_a_q;
	logic              wrap_q;
	logic [SW-1:0]     prod_q;
	logic [FW-1:0]     fnow_q;
	logic [FW-1:0]     fbef_q;
	logic [afs_pkg::BLEND_W-1:0] blend_q;

	logic [SW-1:0]     in_now;
	logic [SW-1:0]     q_now;
	logic [SW-1:0]     per_ext;
	logic [SW-1:0]     cnt_ext;
	logic [SW-1:0]     ceil_num;
	logic [RW-1:0]     rel_new;
	logic [MW-1:0]     mul_full;
	logic [FW-1:0]     frame_off;
	logic [SW-1:0]     bl_num;
	logic [SW-1:0]     bl_den;
	logic [DW-1:0]     bl_dvd;
	logic [afs_pkg::BLEND_W-1:0] bl_q;

	afs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	afs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Operand shaping for compares, divider loads and the frame number
	always_comb begin
		in_now    = {1'b0, time_ms};
		q_now     = {1'b0, now_q};
		per_ext   = SW'(cfg.period);
		cnt_ext   = SW'(cfg.count);
		ceil_num  = in_now - ast_q + per_ext - SW'(1);
		rel_new   = div_quo[RW-1:0];
		frame_off = cfg.rev_en ? (cfg.count - FW'(1) - rel_q[FW-1:0]) : rel_q[FW-1:0];
		bl_num    = q_now - pft_q;
		bl_den    = nft_q - pft_q;
		bl_dvd    = {1'b0, bl_num, 16'b0} + DW'(bl_den[SW-1:1]);
		bl_q      = div_quo[afs_pkg::BLEND_W-1:0];
	end

	// Scale by the frame period; the product is registered every cycle
	assign mul_full = MW'(mul_a_q) * MW'(cfg.period);

	always_ff @(posedge clk) begin
		prod_q <= mul_full[SW-1:0];
	end

	// Sequencer: state, timing state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			now_q     <= '0;
			ast_q     <= '0;
			nft_q     <= '0;
			pft_q     <= '0;
			cur_q     <= '0;
			prv_q     <= '0;
			rel_q     <= '0;
			mul_a_q   <= '0;
			wrap_q    <= 1'b0;
			div_req_q <= '0;
			fnow_q    <= '0;
			fbef_q    <= '0;
			blend_q   <= '0;
		end else begin
			div_req_q.go <= 1'b0;
			case (state_q)
				// Take an event and handle the short kinds at once
				ST_IDLE: begin
					if (in_valid) begin
						now_q <= time_ms;
						case (kind)
							afs_pkg::KIND_START: begin
								ast_q   <= in_now + per_ext;
								cur_q   <= '0;
								prv_q   <= '0;
								nft_q   <= '0;
								pft_q   <= '0;
								fnow_q  <= '0;
								fbef_q  <= '0;
								blend_q <= '0;
								state_q <= ST_OUT;
							end
							afs_pkg::KIND_RESET: begin
								cur_q   <= '0;
								prv_q   <= '0;
								nft_q   <= in_now;
								pft_q   <= in_now;
								fnow_q  <= '0;
								fbef_q  <= '0;
								blend_q <= '0;
								state_q <= ST_OUT;
							end
							afs_pkg::KIND_ADVANCE: begin
								if (in_now <= nft_q) begin
									state_q <= ST_BLEND;
								end else if (in_now < ast_q) begin
									// still in the initial wait
									nft_q   <= ast_q;
									pft_q   <= ast_q;
									prv_q   <= cur_q;
									state_q <= ST_BLEND;
								end else begin
									prv_q              <= cur_q;
									pft_q              <= nft_q;
									div_req_q.go       <= 1'b1;
									div_req_q.steps    <= afs_pkg::DIV_STEPS_FULL;
									div_req_q.rem_init <= '0;
									div_req_q.bits     <= ceil_num;
									div_req_q.divisor  <= per_ext;
									state_q            <= ST_DIV_E;
								end
							end
							default: begin
								fnow_q  <= cur_q;
								fbef_q  <= prv_q;
								blend_q <= '0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				// Frame index is ready: wrap, hold or keep it
				ST_DIV_E: begin
					if (div_done) begin
						if (SW'(rel_new) >= cnt_ext) begin
							if (cfg.loop_en) begin
								rel_q              <= rel_new;
								div_req_q.go       <= 1'b1;
								div_req_q.steps    <= afs_pkg::DIV_STEPS_FULL;
								div_req_q.rem_init <= '0;
								div_req_q.bits     <= SW'(rel_new);
								div_req_q.divisor  <= cnt_ext;
								state_q            <= ST_DIV_N;
							end else begin
								rel_q   <= RW'(cfg.count - FW'(1));
								nft_q   <= q_now;
								state_q <= ST_FRAME;
							end
						end else begin
							rel_q   <= rel_new;
							mul_a_q <= rel_new;
							wrap_q  <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				// Wrapped index is the remainder; scale the full index first
				ST_DIV_N: begin
					if (div_done) begin
						mul_a_q <= rel_q;
						rel_q   <= RW'(div_rem[FW-1:0]);
						wrap_q  <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				// Next frame time from the start time
				ST_SUM: begin
					nft_q <= ast_q + prod_q;
					if (wrap_q) begin
						mul_a_q <= rel_q;
						state_q <= ST_MUL_R;
					end else begin
						state_q <= ST_FRAME;
					end
				end
				ST_MUL_R: begin
					state_q <= ST_AST;
				end
				// Advance the start time by whole loops
				ST_AST: begin
					ast_q   <= nft_q - prod_q;
					state_q <= ST_FRAME;
				end
				ST_FRAME: begin
					cur_q   <= FW'(cfg.first) + frame_off;
					state_q <= ST_BLEND;
				end
				// Blend weight: trivial cases now, otherwise divide
				ST_BLEND: begin
					fnow_q <= cur_q;
					fbef_q <= prv_q;
					if (nft_q <= pft_q) begin
						blend_q <= '0;
						state_q <= ST_OUT;
					end else if (q_now < pft_q) begin
						blend_q <= afs_pkg::ONE_Q16;
						state_q <= ST_OUT;
					end else if (bl_num >= bl_den) begin
						blend_q <= '0;
						state_q <= ST_OUT;
					end else begin
						div_req_q.go       <= 1'b1;
						div_req_q.steps    <= afs_pkg::DIV_STEPS_BLEND;
						div_req_q.rem_init <= bl_dvd[DW-1:afs_pkg::BLEND_W];
						div_req_q.bits     <= {bl_dvd[afs_pkg::BLEND_W-1:0],
							(SW - afs_pkg::BLEND_W)'(0)};
						div_req_q.divisor  <= bl_den;
						state_q            <= ST_DIV_B;
					end
				end
				ST_DIV_B: begin
					if (div_done) begin
						blend_q <= (bl_q > afs_pkg::ONE_Q16) ? '0 : (afs_pkg::ONE_Q16 - bl_q);
						state_q <= ST_OUT;
					end
				end
				// Hold the word until taken
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_OUT);
	assign frame_now    = fnow_q;
	assign frame_before = fbef_q;
	assign blend_back   = blend_q;

endmodule

`default_nettype wire
